// File: design/fss_pkg.sv
// Shared constants, request codes and queue word type of the fuzzy subsequence scorer.
`timescale 1ns / 1ps
`default_nettype none
package fss_pkg;

  localparam int unsigned PATTERN_MAX = 32;
  localparam int unsigned TEXT_MAX    = 512;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned CHAR_W   = 16;
  localparam int unsigned SCORE_W  = 12;
  localparam int unsigned SUBSEQ_W = 11;
  localparam int unsigned TPOS_W   = 10;
  localparam int unsigned PLEN_W   = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IDX_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned ADD_W    = 6;

  // Request codes as they arrive on the request channel.
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEXT   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SCORE  = 2'd3;

  localparam logic [SCORE_W-1:0]  SCORE_EMPTY       = 12'd1000;
  localparam logic [SCORE_W-1:0]  SCORE_SUBSTR_BASE = 12'd3000;
  localparam logic [ADD_W-1:0]    BONUS_MATCH       = 6'd10;
  localparam logic [ADD_W-1:0]    BONUS_WORD        = 6'd10;
  localparam logic [ADD_W-1:0]    BONUS_CONSEC      = 6'd15;
  localparam logic [SUBSEQ_W-1:0] SUBSEQ_LIMIT      = 11'd2047;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 16'h0020;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 16'h003A;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_TEXT,
    OP_SCORE
  } op_e;

  // One decoded word as it travels from the front part to the back part.
  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic              is_sep;
  } item_t;

endpackage
`default_nettype wire

// File: design/fss_if.sv
// Request and response channel interfaces of the fuzzy subsequence scorer.
`timescale 1ns / 1ps
`default_nettype none
interface fss_req_if;
  import fss_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface fss_rsp_if;
  import fss_pkg::*;

  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic               pattern_overflow;
  logic               text_overflow;

  modport source (output valid, output score, output pattern_overflow,
                  output text_overflow, input ready);
  modport sink   (input valid, input score, input pattern_overflow,
                  input text_overflow, output ready);
endinterface
`default_nettype wire

// File: design/fuzzy_subsequence_scorer.sv
// Top level of the fuzzy subsequence scorer: front part, queue and back part.
//
// The scorer takes one request word per cycle when not stalled, and holds a
// pattern of up to PATTERN_MAX UTF-16 code units against which a stream of
// already lowercased text units is scored. A clear word empties the pattern,
// an append word adds one unit, a text word feeds one unit of the text and a
// score word closes the text and yields exactly one response word carrying
// the score and the two overflow flags; all other words yield no response.
// An empty pattern scores 1000, a text that holds the pattern as a substring
// scores 3000 minus the first start position, a text that holds it only as an
// in-order subsequence gets the greedy bonus sum (saturating at 2047), and
// anything else scores 0. Each text unit is compared with every stored
// pattern unit in parallel, so the throughput is one word per cycle when
// not stalled; a score response is registered in the queue and then in the
// response register before it is offered to the receiver.
// A two-word queue separates the front part from the back part, and the
// response register lets new words be accepted while an earlier response
// waits to be taken; only a score word waits for that register to drain.
// Text units beyond TEXT_MAX and pattern units beyond PATTERN_MAX are dropped
// and reported through the overflow flags of the next response.
`timescale 1ns / 1ps
`default_nettype none
module fuzzy_subsequence_scorer (
  input  logic      clk_i,
  input  logic      rst_ni,
  fss_req_if.sink   req_i,
  fss_rsp_if.source rsp_o
);
  import fss_pkg::*;

  logic  push;
  logic  room;
  logic  avail;
  logic  pop;
  item_t front_item;
  item_t back_item;

  fss_front u_front (
    .req_i  (req_i),
    .push_o (push),
    .item_o (front_item),
    .room_i (room)
  );

  fss_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .room_o  (room),
    .avail_o (avail),
    .item_o  (back_item),
    .pop_i   (pop)
  );

  fss_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .item_i  (back_item),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule
`default_nettype wire

// File: design/fss_front.sv
// Front part: accepts request words and decodes them into queue words.
`timescale 1ns / 1ps
`default_nettype none
module fss_front (
  fss_req_if.sink          req_i,
  output logic             push_o,
  output fss_pkg::item_t   item_o,
  input  logic             room_i
);
  import fss_pkg::*;

  op_e op;

  always_comb begin
    unique case (req_i.req_type)
      REQ_CLEAR:  op = OP_CLEAR;
      REQ_APPEND: op = OP_APPEND;
      REQ_TEXT:   op = OP_TEXT;
      default:    op = OP_SCORE;
    endcase
  end

  assign req_i.ready      = room_i;
  assign push_o           = req_i.valid && room_i;
  assign item_o.op        = op;
  assign item_o.char_code = req_i.char_code;
  // Word separators are spotted here so the back part sees a single flag.
  assign item_o.is_sep    = (req_i.char_code == CHAR_SPACE) ||
                            (req_i.char_code == CHAR_COLON);

endmodule
`default_nettype wire

// File: design/fss_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module fss_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fss_pkg::item_t item_i,
  output logic           room_o,
  output logic           avail_o,
  output fss_pkg::item_t item_o,
  input  logic           pop_i
);
  import fss_pkg::*;

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign room_o  = (count_q != 2'd2);
  assign avail_o = (count_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// File: design/fss_back.sv
// Back part: pattern store, shift-and and subsequence scoring, result register.
`timescale 1ns / 1ps
`default_nettype none
module fss_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  fss_pkg::item_t item_i,
  output logic           pop_o,
  fss_rsp_if.source      rsp_o
);
  import fss_pkg::*;

  logic [CHAR_W-1:0]      pat_q [PATTERN_MAX];
  logic [PLEN_W-1:0]      plen_q, plen_d;
  logic                   pdrop_q, pdrop_d;
  logic [PATTERN_MAX-1:0] pmv_q, pmv_d;
  logic                   found_q, found_d;
  logic [TPOS_W-1:0]      start_q, start_d;
  logic [TPOS_W-1:0]      tpos_q, tpos_d;
  logic [PLEN_W-1:0]      mcnt_q, mcnt_d;
  logic                   pmatch_q, pmatch_d;
  logic                   psep_q, psep_d;
  logic [SUBSEQ_W-1:0]    sub_q, sub_d;
  logic                   tdrop_q, tdrop_d;

  logic                   out_valid_q, out_valid_d;
  logic [SCORE_W-1:0]     score_q, score_d;
  logic                   povf_q, tovf_q;

  logic [PATTERN_MAX-1:0] eq;
  logic [PATTERN_MAX-1:0] pmv_shift;
  logic [IDX_W-1:0]       last_idx;
  logic                   found_now;
  logic                   hit;
  logic [ADD_W-1:0]       add;
  logic [SUBSEQ_W:0]      sum;
  logic                   text_full;
  logic                   slot_free;
  logic                   do_append;
  logic                   restart;

  // Each text word is compared with every pattern entry at once.
  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      eq[i] = (PLEN_W'(i) < plen_q) && (pat_q[i] == item_i.char_code);
    end
  end

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign pop_o     = avail_i && ((item_i.op != OP_SCORE) || slot_free);
  assign do_append = pop_o && (item_i.op == OP_APPEND) &&
                     (plen_q < PLEN_W'(PATTERN_MAX));
  assign restart   = pop_o && (item_i.op != OP_TEXT);

  assign pmv_shift = ((pmv_q << 1) | PATTERN_MAX'(1)) & eq;
  assign last_idx  = IDX_W'(plen_q - PLEN_W'(1));
  assign found_now = (plen_q != '0) && !found_q && pmv_shift[last_idx];
  assign hit       = (mcnt_q < plen_q) && eq[mcnt_q[IDX_W-1:0]];
  assign text_full = (tpos_q >= TPOS_W'(TEXT_MAX));

  always_comb begin
    add = BONUS_MATCH;
    if (pmatch_q) begin
      add = add + BONUS_CONSEC;
    end
    if (psep_q) begin
      add = add + BONUS_WORD;
    end
    sum = {1'b0, sub_q} + (SUBSEQ_W + 1)'(add);
  end

  always_comb begin
    plen_d   = plen_q;
    pdrop_d  = pdrop_q;
    pmv_d    = pmv_q;
    found_d  = found_q;
    start_d  = start_q;
    tpos_d   = tpos_q;
    mcnt_d   = mcnt_q;
    pmatch_d = pmatch_q;
    psep_d   = psep_q;
    sub_d    = sub_q;
    tdrop_d  = tdrop_q;

    if (pop_o) begin
      unique case (item_i.op)
        OP_CLEAR: begin
          plen_d  = '0;
          pdrop_d = 1'b0;
        end
        OP_APPEND: begin
          if (do_append) begin
            plen_d = plen_q + PLEN_W'(1);
          end else begin
            pdrop_d = 1'b1;
          end
        end
        OP_TEXT: begin
          if (text_full) begin
            tdrop_d = 1'b1;
          end else begin
            pmv_d = pmv_shift;
            if (found_now) begin
              found_d = 1'b1;
              start_d = tpos_q + TPOS_W'(1) - TPOS_W'(plen_q);
            end
            if (hit) begin
              sub_d  = sum[SUBSEQ_W] ? SUBSEQ_LIMIT : sum[SUBSEQ_W-1:0];
              mcnt_d = mcnt_q + PLEN_W'(1);
            end
            pmatch_d = hit;
            psep_d   = item_i.is_sep;
            tpos_d   = tpos_q + TPOS_W'(1);
          end
        end
        default: begin
        end
      endcase
    end

    if (restart) begin
      pmv_d    = '0;
      found_d  = 1'b0;
      start_d  = '0;
      tpos_d   = '0;
      mcnt_d   = '0;
      pmatch_d = 1'b1;
      psep_d   = 1'b1;
      sub_d    = '0;
      tdrop_d  = 1'b0;
    end
  end

  always_comb begin
    priority if (plen_q == '0) begin
      score_d = SCORE_EMPTY;
    end else if (found_q) begin
      score_d = SCORE_SUBSTR_BASE - SCORE_W'(start_q);
    end else if (mcnt_q == plen_q) begin
      score_d = SCORE_W'(sub_q);
    end else begin
      score_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (pop_o && (item_i.op == OP_SCORE)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      pdrop_q     <= 1'b0;
      pmv_q       <= '0;
      found_q     <= 1'b0;
      start_q     <= '0;
      tpos_q      <= '0;
      mcnt_q      <= '0;
      pmatch_q    <= 1'b1;
      psep_q      <= 1'b1;
      sub_q       <= '0;
      tdrop_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      plen_q      <= plen_d;
      pdrop_q     <= pdrop_d;
      pmv_q       <= pmv_d;
      found_q     <= found_d;
      start_q     <= start_d;
      tpos_q      <= tpos_d;
      mcnt_q      <= mcnt_d;
      pmatch_q    <= pmatch_d;
      psep_q      <= psep_d;
      sub_q       <= sub_d;
      tdrop_q     <= tdrop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_append) begin
      pat_q[plen_q[IDX_W-1:0]] <= item_i.char_code;
    end
    if (pop_o && (item_i.op == OP_SCORE)) begin
      score_q <= score_d;
      povf_q  <= pdrop_q;
      tovf_q  <= tdrop_q;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.score            = score_q;
  assign rsp_o.pattern_overflow = povf_q;
  assign rsp_o.text_overflow    = tovf_q;

endmodule
`default_nettype wire

// File: sim/fuzzy_subsequence_scorer_tb.sv
// Self-checking testbench of the fuzzy subsequence scorer with its own scoring predictor.
`timescale 1ns / 1ps
`default_nettype none
module fuzzy_subsequence_scorer_tb;
  import fss_pkg::*;

  // Run length and pacing.
  localparam int unsigned TOTAL_WORDS      = 950;
  localparam int unsigned LONG_TEXT_PRE    = 498;
  localparam int unsigned LONG_TEXT_POST   = 20;
  localparam int unsigned QUIET_WORDS      = 150;
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES     = 10;
  localparam int unsigned MAX_REPORTS      = 60;
  localparam int unsigned TIMEOUT_NS       = 4_000_000;

  // A few lowercase code units used by the directed words.
  localparam logic [CHAR_W-1:0] CH_A = 16'h0061;
  localparam logic [CHAR_W-1:0] CH_B = 16'h0062;
  localparam logic [CHAR_W-1:0] CH_X = 16'h0078;

  // Shapes of text that the random part builds against the current pattern.
  typedef enum int unsigned {
    TXT_EMPTY,
    TXT_FILL,
    TXT_SUBSTR,
    TXT_SUBSEQ,
    TXT_BROKEN
  } text_kind_e;

  // One expected response word.
  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               pattern_overflow;
    logic               text_overflow;
  } score_word_t;

  // The predictor keeps its own copy of the pattern and of the text-side
  // state, works out the score of every closed text and queues it until the
  // matching response word turns up.
  class score_predictor;
    logic [CHAR_W-1:0]      pat_units [PATTERN_MAX];
    int unsigned            pat_len;
    bit                     pat_dropped;
    logic [PATTERN_MAX-1:0] partial_hits;
    bit                     found;
    int unsigned            found_at;
    int unsigned            text_pos;
    int unsigned            seq_matched;
    bit                     last_hit;
    bit                     last_sep;
    int unsigned            seq_score;
    bit                     text_dropped;
    score_word_t            pending_scores [$];
    int unsigned            mismatches;

    function new();
      pat_len     = 0;
      pat_dropped = 1'b0;
      mismatches  = 0;
      restart_text();
    endfunction

    function void restart_text();
      partial_hits = '0;
      found        = 1'b0;
      found_at     = 0;
      text_pos     = 0;
      seq_matched  = 0;
      last_hit     = 1'b1;
      last_sep     = 1'b1;
      seq_score    = 0;
      text_dropped = 1'b0;
    endfunction

    function void take_unit(logic [CHAR_W-1:0] c);
      logic [PATTERN_MAX-1:0] eq;
      int unsigned            add;
      if (text_pos >= TEXT_MAX) begin
        text_dropped = 1'b1;
        return;
      end
      eq = '0;
      for (int i = 0; i < int'(pat_len); i++) begin
        if (pat_units[i] == c) eq[i] = 1'b1;
      end
      // Shift-and: bit i set means the last i+1 units equal the pattern prefix.
      partial_hits = {partial_hits[PATTERN_MAX-2:0], 1'b1} & eq;
      if (pat_len > 0 && !found && partial_hits[pat_len-1]) begin
        found    = 1'b1;
        found_at = text_pos + 1 - pat_len;
      end
      // Greedy in-order match against the next unmatched pattern unit.
      if (seq_matched < pat_len && pat_units[seq_matched] == c) begin
        add = int'(BONUS_MATCH);
        if (last_hit) add += int'(BONUS_CONSEC);
        if (last_sep) add += int'(BONUS_WORD);
        seq_score += add;
        if (seq_score > int'(SUBSEQ_LIMIT)) seq_score = int'(SUBSEQ_LIMIT);
        seq_matched++;
        last_hit = 1'b1;
      end else begin
        last_hit = 1'b0;
      end
      last_sep = (c == CHAR_SPACE) || (c == CHAR_COLON);
      text_pos++;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] c);
      score_word_t w;
      case (req)
        REQ_CLEAR: begin
          pat_len     = 0;
          pat_dropped = 1'b0;
          restart_text();
        end
        REQ_APPEND: begin
          if (pat_len < PATTERN_MAX) begin
            pat_units[pat_len] = c;
            pat_len++;
          end else begin
            pat_dropped = 1'b1;
          end
          restart_text();
        end
        REQ_TEXT: begin
          take_unit(c);
        end
        default: begin
          if (pat_len == 0) w.score = SCORE_EMPTY;
          else if (found) w.score = SCORE_SUBSTR_BASE - SCORE_W'(found_at);
          else if (seq_matched == pat_len) w.score = SCORE_W'(seq_score);
          else w.score = '0;
          w.pattern_overflow = pat_dropped;
          w.text_overflow    = text_dropped;
          pending_scores.push_back(w);
          restart_text();
        end
      endcase
    endfunction

    task flag_mismatch(string what, int unsigned got_v, int unsigned want_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got_v, want_v);
    endtask

    task check_response(logic [SCORE_W-1:0] score, logic p_ovf, logic t_ovf);
      score_word_t w;
      if (pending_scores.size() == 0) begin
        flag_mismatch("response with no score outstanding", 32'(score), 0);
        return;
      end
      w = pending_scores.pop_front();
      if (score !== w.score) flag_mismatch("score", 32'(score), 32'(w.score));
      if (p_ovf !== w.pattern_overflow)
        flag_mismatch("pattern_overflow", 32'(p_ovf), 32'(w.pattern_overflow));
      if (t_ovf !== w.text_overflow)
        flag_mismatch("text_overflow", 32'(t_ovf), 32'(w.text_overflow));
    endtask

    function int unsigned outstanding();
      return pending_scores.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fss_req_if req_if ();
  fss_rsp_if rsp_if ();

  fuzzy_subsequence_scorer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  score_predictor board = new();

  // Pacing controls shared by the sender and the receiver.
  bit send_idle;
  bit rsp_idle;
  bit long_hold_request;

  // The sender's own view of the pattern, used only to build texts that
  // actually hit it; the predictor keeps its own copy for checking.
  logic [CHAR_W-1:0] cur_pat [PATTERN_MAX];
  int                cur_len;
  int unsigned       words_sent;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Mostly lowercase letters, then separators, and now and then any code
  // unit at all so that every bit of char_code is exercised.
  function automatic logic [CHAR_W-1:0] filler_unit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return CHAR_W'(16'h0061 + $urandom_range(0, 7));
    if (r < 80) return CHAR_SPACE;
    if (r < 88) return CHAR_COLON;
    return CHAR_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_unit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return CHAR_W'(16'h0061 + $urandom_range(0, 5));
    if (r < 80) return (r < 72) ? CHAR_SPACE : CHAR_COLON;
    return CHAR_W'($urandom_range(0, 65535));
  endfunction

  function automatic text_kind_e pick_text_kind();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return TXT_EMPTY;
    if (r < 3) return TXT_FILL;
    if (r < 6) return TXT_SUBSTR;
    if (r < 9) return TXT_SUBSEQ;
    return TXT_BROKEN;
  endfunction

  // Offers one request word and holds it until it is accepted. A gap, when
  // one is drawn, lowers valid at one falling edge and raises it again at a
  // later one, never both at the same edge. Back-to-back words keep valid
  // high throughout.
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch);
    int unsigned gap;
    gap = (send_idle && $urandom_range(0, 11) == 0) ? $urandom_range(1, 18) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= req;
    req_if.char_code <= ch;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(req, ch);
    words_sent++;
    case (req)
      REQ_CLEAR: begin
        cur_len = 0;
      end
      REQ_APPEND: begin
        if (cur_len < int'(PATTERN_MAX)) begin
          cur_pat[cur_len] = ch;
          cur_len++;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic load_pattern(input int unsigned len);
    send_word(REQ_CLEAR, CHAR_W'($urandom_range(0, 65535)));
    repeat (len) send_word(REQ_APPEND, pattern_unit());
  endtask

  // Streams one text built around the current pattern and closes it with a
  // score word. A broken subsequence leaves one pattern unit out.
  task automatic send_text(input text_kind_e kind, input int unsigned pre,
                           input int unsigned post);
    int skip;
    skip = (cur_len != 0) ? int'($urandom_range(0, cur_len - 1)) : 0;
    case (kind)
      TXT_FILL: begin
        repeat (pre) send_word(REQ_TEXT, filler_unit());
      end
      TXT_SUBSTR: begin
        repeat (pre) send_word(REQ_TEXT, filler_unit());
        for (int i = 0; i < cur_len; i++) send_word(REQ_TEXT, cur_pat[i]);
        repeat (post) send_word(REQ_TEXT, filler_unit());
      end
      TXT_SUBSEQ, TXT_BROKEN: begin
        for (int i = 0; i < cur_len; i++) begin
          repeat ($urandom_range(0, 2)) send_word(REQ_TEXT, filler_unit());
          if (!(kind == TXT_BROKEN && i == skip)) send_word(REQ_TEXT, cur_pat[i]);
        end
      end
      default: begin
      end
    endcase
    send_word(REQ_SCORE, CHAR_W'($urandom_range(0, 65535)));
  endtask

  // Stops offering words until every outstanding score has come back.
  task automatic pause_until_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  // Receiver: ready is decided at each falling edge. A long hold, once asked
  // for by the sender, is counted out here cycle by cycle; otherwise random
  // stall bursts come and go while rsp_idle is set.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left     = 0;
    stall_left    = 0;
    rsp_if.ready  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        hold_left         = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (rsp_idle && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
      end
    end
  end

  // Every response word taken at a rising edge is checked against the oldest
  // expected score.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      board.check_response(rsp_if.score, rsp_if.pattern_overflow, rsp_if.text_overflow);
  end

  // Stimulus: directed words, a back-pressure phase, then random sequences.
  initial begin
    int unsigned r;
    bit          long_done;
    bit          full_done;
    bit          drain_done;
    long_done         = 1'b0;
    full_done         = 1'b0;
    drain_done        = 1'b0;
    send_idle         = 1'b0;
    rsp_idle          = 1'b0;
    long_hold_request = 1'b0;
    cur_len           = 0;
    words_sent        = 0;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_CLEAR;
    req_if.char_code  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty pattern straight after reset, with and without text units.
    send_word(REQ_SCORE, 16'hFFFF);
    send_word(REQ_TEXT, 16'h0000);
    send_word(REQ_SCORE, 16'h0000);
    // Pattern "ab" found as a substring at position 0.
    send_word(REQ_APPEND, CH_A);
    send_word(REQ_APPEND, CH_B);
    send_word(REQ_TEXT, CH_A);
    send_word(REQ_TEXT, CH_B);
    send_word(REQ_SCORE, 16'h0000);
    // Subsequence only, with a word start after a colon.
    send_word(REQ_TEXT, CH_X);
    send_word(REQ_TEXT, CH_A);
    send_word(REQ_TEXT, CHAR_COLON);
    send_word(REQ_TEXT, CH_B);
    send_word(REQ_SCORE, 16'h0000);
    // Units out of order after a space: an incomplete match scores nothing.
    send_word(REQ_TEXT, CHAR_SPACE);
    send_word(REQ_TEXT, CH_B);
    send_word(REQ_TEXT, CH_A);
    send_word(REQ_SCORE, 16'h0000);
    // Empty text against a non-empty pattern.
    send_word(REQ_SCORE, 16'hFFFF);
    // Extreme code units in both the pattern and the text.
    send_word(REQ_CLEAR, 16'hFFFF);
    send_word(REQ_APPEND, 16'hFFFF);
    send_word(REQ_APPEND, 16'h0000);
    send_word(REQ_TEXT, 16'hFFFF);
    send_word(REQ_TEXT, 16'h0000);
    send_word(REQ_SCORE, 16'h0000);

    // Back-pressure: the receiver holds off for a long stretch while score
    // words keep coming, so the queue fills and the input must stall.
    long_hold_request = 1'b1;
    repeat (10) begin
      send_word(REQ_TEXT, filler_unit());
      send_word(REQ_SCORE, CHAR_W'($urandom_range(0, 65535)));
    end

    // Random sequences: mostly a pattern load followed by texts shaped to hit
    // it, with some noise words in between. The one text that runs past the
    // text capacity takes up a good part of the budget.
    while (words_sent < TOTAL_WORDS) begin
      if (words_sent + QUIET_WORDS > TOTAL_WORDS) begin
        send_idle = 1'b0;
        rsp_idle  = 1'b0;
      end else begin
        send_idle = ($urandom_range(0, 3) != 0);
        rsp_idle  = ($urandom_range(0, 3) != 0);
      end
      if (!full_done && words_sent > 150) begin
        // Pattern overflow: the stored prefix must still be matched.
        full_done = 1'b1;
        load_pattern($urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4));
        send_text(TXT_SUBSTR, $urandom_range(0, 4), $urandom_range(0, 3));
        send_text(TXT_SUBSEQ, 0, 0);
      end else if (!long_done && words_sent > 300) begin
        // A text past the capacity, with the pattern late in the kept part.
        long_done = 1'b1;
        load_pattern($urandom_range(1, 3));
        send_text(TXT_SUBSTR, LONG_TEXT_PRE, LONG_TEXT_POST);
      end else if (!drain_done && words_sent > 900) begin
        drain_done = 1'b1;
        pause_until_drained();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          repeat ($urandom_range(1, 6))
            send_word(REQ_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 65535)));
        end else begin
          if (r < 45)
            load_pattern(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
          repeat ($urandom_range(1, 3))
            send_text(pick_text_kind(), $urandom_range(0, 6), $urandom_range(0, 3));
        end
      end
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("fuzzy_subsequence_scorer_tb: done, clean");
    end else begin
      $display("fuzzy_subsequence_scorer_tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("fuzzy_subsequence_scorer_tb: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
design/fss_pkg.sv
design/fss_if.sv
design/fss_front.sv
design/fss_queue.sv
design/fss_back.sv
design/fuzzy_subsequence_scorer.sv
sim/fuzzy_subsequence_scorer_tb.sv
